FILE: rtl/core/uhv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package uhv_pkg;

  localparam int unsigned HEADER_BYTES = 64;
  localparam logic [31:0] UIMAGE_MAGIC = 32'h2705_1956;
  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [31:0] CRC_PRESET   = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    VERDICT_OK        = 3'd0,
    VERDICT_TOO_SHORT = 3'd1,
    VERDICT_BAD_MAGIC = 3'd2,
    VERDICT_BAD_HCRC  = 3'd3,
    VERDICT_BAD_DCRC  = 3'd4,
    VERDICT_TOO_BIG   = 3'd5
  } verdict_t;

endpackage

`default_nettype wire

FILE: rtl/core/uhv_crc_byte.sv
`timescale 1ns / 1ps
`default_nettype none

module uhv_crc_byte (
  input  wire logic [31:0] crc_in,
  input  wire logic [7:0]  data_in,
  output logic      [31:0] crc_out
);
  import uhv_pkg::*;

  logic [31:0] acc;

  // reflected CRC-32, one bit per step
  always_comb begin
    acc = crc_in ^ {24'd0, data_in};
    for (int k = 0; k < 8; k++) begin
      acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
    end
    crc_out = acc;
  end

endmodule

`default_nettype wire

FILE: rtl/core/uimage_header_verifier.sv
`timescale 1ns / 1ps
`default_nettype none

// Streams a legacy boot image one byte per item and gives one verdict item
// per image, on the byte flagged last: 0 ok, 1 too short, 2 bad magic,
// 3 bad header CRC, 4 bad data CRC, 5 larger than cfg_write_data's limit,
// with the saturating byte count. One byte is taken every cycle. The one
// exception is a last byte: it waits in the input register while the previous
// verdict is held by out_stall. The edge that accepts the last byte loads it
// into the input register; the edge on which it advances writes the byte-wide
// CRC-32 update and checks into the result register and sets out_valid. Write
// the partition limit only while no image is in flight.
module uimage_header_verifier #(
  parameter int unsigned LENGTH_BITS = 28
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             in_image_byte,
  input  wire logic                   in_last_byte,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [2:0]                  out_verdict,
  output logic [LENGTH_BITS-1:0]      out_image_length,
  input  wire logic                   cfg_write_en,
  input  wire logic [LENGTH_BITS-1:0] cfg_write_data
);
  import uhv_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] HDR_LEN = LENGTH_BITS'(HEADER_BYTES);

  // input register
  logic                   s1_valid_r;
  logic [7:0]             s1_byte_r;
  logic                   s1_last_r;
  logic                   s1_adv;

  // image state
  logic [LENGTH_BITS-1:0] count_r, count_nxt;
  logic [31:0]            crc_r, crc_nxt;
  logic [31:0]            magic_r, magic_nxt;
  logic [31:0]            hcrc_r, hcrc_nxt;
  logic [31:0]            dcrc_r, dcrc_nxt;
  logic                   hgood_r, hgood_nxt;
  logic [LENGTH_BITS-1:0] limit_r;

  // result register
  logic                   out_valid_r;
  verdict_t               verdict_r, verdict_nxt;
  logic [LENGTH_BITS-1:0] length_r;

  logic                   in_hdr;
  logic [5:0]             hidx;
  logic                   hcrc_pos;
  logic [7:0]             crc_data;
  logic [31:0]            crc_upd;
  logic [LENGTH_BITS-1:0] count_inc;
  logic [31:0]            crc_fin;

  assign s1_adv   = s1_valid_r && !(s1_last_r && out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !s1_adv;

  assign in_hdr   = count_r < HDR_LEN;
  assign hidx     = count_r[5:0];
  assign hcrc_pos = in_hdr && (hidx >= 6'd4) && (hidx < 6'd8);
  assign crc_data = hcrc_pos ? 8'd0 : s1_byte_r;

  uhv_crc_byte u_crc (
    .crc_in  (crc_r),
    .data_in (crc_data),
    .crc_out (crc_upd)
  );

  always_comb begin
    magic_nxt = magic_r;
    hcrc_nxt  = hcrc_r;
    dcrc_nxt  = dcrc_r;
    hgood_nxt = hgood_r;
    crc_nxt   = crc_upd;
    if (in_hdr) begin
      if (hidx < 6'd4) begin
        magic_nxt = {magic_r[23:0], s1_byte_r};
      end else if (hidx < 6'd8) begin
        hcrc_nxt = {hcrc_r[23:0], s1_byte_r};
      end else if ((hidx >= 6'd24) && (hidx < 6'd28)) begin
        dcrc_nxt = {dcrc_r[23:0], s1_byte_r};
      end
      if (hidx == 6'd63) begin
        hgood_nxt = (~crc_upd) == hcrc_r;
        crc_nxt   = CRC_PRESET;
      end
    end
    count_inc = (count_r == LEN_MAX) ? count_r : count_r + LENGTH_BITS'(1);
    count_nxt = count_inc;
    crc_fin   = ~crc_nxt;

    if (count_inc < HDR_LEN) begin
      verdict_nxt = VERDICT_TOO_SHORT;
    end else if (magic_nxt != UIMAGE_MAGIC) begin
      verdict_nxt = VERDICT_BAD_MAGIC;
    end else if (!hgood_nxt) begin
      verdict_nxt = VERDICT_BAD_HCRC;
    end else if (crc_fin != dcrc_nxt) begin
      verdict_nxt = VERDICT_BAD_DCRC;
    end else if (count_inc > limit_r) begin
      verdict_nxt = VERDICT_TOO_BIG;
    end else begin
      verdict_nxt = VERDICT_OK;
    end

    if (s1_last_r) begin
      count_nxt = '0;
      crc_nxt   = CRC_PRESET;
      magic_nxt = '0;
      hcrc_nxt  = '0;
      dcrc_nxt  = '0;
      hgood_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      crc_r       <= CRC_PRESET;
      magic_r     <= '0;
      hcrc_r      <= '0;
      dcrc_r      <= '0;
      hgood_r     <= 1'b0;
      limit_r     <= LEN_MAX;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        count_r <= count_nxt;
        crc_r   <= crc_nxt;
        magic_r <= magic_nxt;
        hcrc_r  <= hcrc_nxt;
        dcrc_r  <= dcrc_nxt;
        hgood_r <= hgood_nxt;
      end
      if (s1_adv && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_write_en) begin
        limit_r <= cfg_write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte_r <= in_image_byte;
      s1_last_r <= in_last_byte;
    end
    if (s1_adv && s1_last_r) begin
      verdict_r <= verdict_nxt;
      length_r  <= count_inc;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_verdict      = verdict_r;
  assign out_image_length = length_r;

endmodule

`default_nettype wire

FILE: rtl/core/uhv_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module uhv_props #(
  parameter int unsigned LENGTH_BITS = 28
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_stall,
  input wire logic                   in_last_byte,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic [2:0]             out_verdict,
  input wire logic [LENGTH_BITS-1:0] out_image_length
);
  import uhv_pkg::*;

  localparam logic [LENGTH_BITS-1:0] HDR_LEN = LENGTH_BITS'(HEADER_BYTES);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_verdict) &&
      $stable(out_image_length))
    else $error("result changed while stalled");

  a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_verdict <= VERDICT_TOO_BIG)
    else $error("verdict code out of range");

  a_short_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_verdict == VERDICT_TOO_SHORT) |-> out_image_length < HDR_LEN)
    else $error("too short verdict with full header");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_verdict != VERDICT_TOO_SHORT) |-> out_image_length >= HDR_LEN)
    else $error("header checks on a short image");

  // a rise of out_valid follows the edge after its last byte was accepted
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_last_byte, 2))
    else $error("result without a cause");

endmodule

bind uimage_header_verifier uhv_props #(.LENGTH_BITS(LENGTH_BITS)) u_uhv_props (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_last_byte     (in_last_byte),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_verdict      (out_verdict),
  .out_image_length (out_image_length)
);

`default_nettype wire

FILE: test/uhv_checker.sv
`timescale 1ns / 1ps

module uhv_checker #(
  parameter int unsigned LENGTH_BITS = 28
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic                   in_stall,
  input  wire logic [7:0]             in_image_byte,
  input  wire logic                   in_last_byte,
  input  wire logic                   out_valid,
  input  wire logic                   out_stall,
  input  wire logic [2:0]             out_verdict,
  input  wire logic [LENGTH_BITS-1:0] out_image_length,
  input  wire logic                   cfg_write_en,
  input  wire logic [LENGTH_BITS-1:0] cfg_write_data,
  output int                          failures,
  output int                          pending
);

  import uhv_pkg::*;

  typedef struct {
    verdict_t               verdict;
    logic [LENGTH_BITS-1:0] length;
  } verdict_item_t;

  verdict_item_t          verdict_q[$];
  logic [LENGTH_BITS-1:0] size_limit;
  logic [LENGTH_BITS-1:0] byte_total;
  logic [31:0]            crc_acc;
  logic [31:0]            magic;
  logic [31:0]            hdr_crc_field;
  logic [31:0]            data_crc_field;
  logic                   hdr_ok;

  function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    int k;
    r = c ^ {24'h0, d};
    for (k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  task automatic clear_image();
    byte_total     = '0;
    crc_acc        = CRC_PRESET;
    magic          = '0;
    hdr_crc_field  = '0;
    data_crc_field = '0;
    hdr_ok         = 1'b0;
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic last);
    int unsigned   idx;
    verdict_item_t item;
    idx = byte_total;
    if (idx < HEADER_BYTES) begin
      if (idx < 4) begin
        magic = {magic[23:0], b};
      end else if (idx < 8) begin
        hdr_crc_field = {hdr_crc_field[23:0], b};
      end else if (idx >= 24 && idx < 28) begin
        data_crc_field = {data_crc_field[23:0], b};
      end
      crc_acc = crc32_byte(crc_acc, (idx >= 4 && idx < 8) ? 8'h00 : b);
      if (idx == HEADER_BYTES - 1) begin
        hdr_ok  = ((~crc_acc) == hdr_crc_field);
        crc_acc = CRC_PRESET;
      end
    end else begin
      crc_acc = crc32_byte(crc_acc, b);
    end
    if (byte_total != '1) byte_total++;
    if (last) begin
      item.length = byte_total;
      if (byte_total < HEADER_BYTES) item.verdict = VERDICT_TOO_SHORT;
      else if (magic != UIMAGE_MAGIC) item.verdict = VERDICT_BAD_MAGIC;
      else if (!hdr_ok) item.verdict = VERDICT_BAD_HCRC;
      else if ((~crc_acc) != data_crc_field) item.verdict = VERDICT_BAD_DCRC;
      else if (byte_total > size_limit) item.verdict = VERDICT_TOO_BIG;
      else item.verdict = VERDICT_OK;
      verdict_q.push_back(item);
      clear_image();
    end
  endtask

  always @(posedge clk) begin
    verdict_item_t want;
    if (!rst_n) begin
      clear_image();
      size_limit = '1;
      verdict_q.delete();
    end else begin
      if (cfg_write_en) size_limit = cfg_write_data;
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected item: verdict %0d length %0d", out_verdict, out_image_length);
        end else begin
          want = verdict_q.pop_front();
          if (out_verdict !== want.verdict || out_image_length !== want.length) begin
            failures++;
            if (failures <= 10)
              $display("mismatch: verdict exp %0d got %0d, length exp %0d got %0d",
                       want.verdict, out_verdict, want.length, out_image_length);
          end
        end
      end
      if (in_valid && !in_stall) absorb_byte(in_image_byte, in_last_byte);
    end
    pending = verdict_q.size();
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;

  import uhv_pkg::*;

  localparam int unsigned LEN_W = 28;

  typedef enum {
    IMG_GOOD,
    IMG_BAD_MAGIC,
    IMG_BAD_HCRC,
    IMG_BAD_DCRC,
    IMG_SHORT,
    IMG_NOISE
  } img_kind_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_image_byte = 8'h00;
  logic             in_last_byte = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [2:0]       out_verdict;
  logic [LEN_W-1:0] out_image_length;
  logic             cfg_write_en = 1'b0;
  logic [LEN_W-1:0] cfg_write_data = '0;
  int               failures;
  int               pending;

  int               idle_pct = 0;
  int               stall_pct = 0;
  bit               hold_req = 1'b0;
  int               hold_left = 0;
  logic [7:0]       img_q[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  uimage_header_verifier #(.LENGTH_BITS(LEN_W)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_image_byte    (in_image_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_verdict      (out_verdict),
    .out_image_length (out_image_length),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data)
  );

  uhv_checker #(.LENGTH_BITS(LEN_W)) chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_image_byte    (in_image_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_verdict      (out_verdict),
    .out_image_length (out_image_length),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .failures         (failures),
    .pending          (pending)
  );

  // receiver side: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (hold_req) begin
      out_stall = 1'b1;
      hold_left = 299;
      hold_req  = 1'b0;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [31:0] next_crc(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    int k;
    r = c ^ {24'h0, d};
    for (k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  task automatic flip_bit(input int pos);
    img_q[pos] = img_q[pos] ^ (8'h01 << $urandom_range(7));
  endtask

  // short and noise images take len as total size, the rest as payload size
  task automatic build_image(input img_kind_t kind, input int len);
    logic [31:0] c;
    int i;
    img_q.delete();
    if (kind == IMG_SHORT || kind == IMG_NOISE) begin
      for (i = 0; i < len; i++) img_q.push_back(8'($urandom));
      if (len >= 4 && $urandom_range(1)) begin
        for (i = 0; i < 4; i++) img_q[i] = UIMAGE_MAGIC[31-8*i -: 8];
      end
      return;
    end
    for (i = 0; i < 64 + len; i++) img_q.push_back(8'($urandom));
    for (i = 0; i < 4; i++) img_q[i] = UIMAGE_MAGIC[31-8*i -: 8];
    if (kind == IMG_BAD_MAGIC) flip_bit($urandom_range(3));
    c = CRC_PRESET;
    for (i = 0; i < len; i++) c = next_crc(c, img_q[64+i]);
    c = ~c;
    for (i = 0; i < 4; i++) img_q[24+i] = c[31-8*i -: 8];
    if (kind == IMG_BAD_DCRC) begin
      if (len > 0 && $urandom_range(1)) flip_bit(64 + $urandom_range(len - 1));
      else flip_bit(24 + $urandom_range(3));
    end
    c = CRC_PRESET;
    for (i = 0; i < 64; i++) c = next_crc(c, (i >= 4 && i < 8) ? 8'h00 : img_q[i]);
    c = ~c;
    for (i = 0; i < 4; i++) img_q[4+i] = c[31-8*i -: 8];
    if (kind == IMG_BAD_HCRC) flip_bit($urandom_range(63, 4));
  endtask

  // entered and left at a falling edge
  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_image_byte = b;
    in_last_byte  = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_image();
    int i;
    for (i = 0; i < img_q.size(); i++) push_byte(img_q[i], i == img_q.size() - 1);
  endtask

  task automatic settle(input int extra);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LEN_W-1:0] v);
    cfg_write_en   = 1'b1;
    cfg_write_data = v;
    @(negedge clk);
    cfg_write_en   = 1'b0;
  endtask

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int p;
    int r;
    int i;
    int phase_bytes;
    int phase_imgs;
    img_kind_t kind;

    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed images
    write_limit('1);
    build_image(IMG_SHORT, 1);
    img_q[0] = 8'h00;
    send_image();
    build_image(IMG_SHORT, 63);
    for (i = 0; i < 63; i++) img_q[i] = 8'hFF;
    send_image();
    build_image(IMG_GOOD, 0);
    send_image();
    build_image(IMG_GOOD, 5);
    send_image();
    build_image(IMG_BAD_MAGIC, 2);
    send_image();
    build_image(IMG_BAD_HCRC, 2);
    send_image();
    build_image(IMG_BAD_DCRC, 3);
    send_image();
    build_image(IMG_NOISE, 64);
    send_image();
    settle(4);
    write_limit(64);
    build_image(IMG_GOOD, 0);
    send_image();
    build_image(IMG_GOOD, 1);
    send_image();

    // random phases
    for (p = 0; p < 8; p++) begin
      settle(4);
      case (p)
        0, 4:    write_limit('1);
        1:       write_limit('0);
        2:       write_limit(64);
        6:       write_limit(LEN_W'($urandom));
        default: write_limit(LEN_W'($urandom_range(140, 64)));
      endcase
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      if (p == 4) hold_req = 1'b1;
      phase_bytes = 0;
      phase_imgs  = 0;
      while (phase_bytes < 100 || phase_imgs < 2) begin
        r = $urandom_range(99);
        if (r < 35) kind = IMG_GOOD;
        else if (r < 45) kind = IMG_BAD_MAGIC;
        else if (r < 55) kind = IMG_BAD_HCRC;
        else if (r < 65) kind = IMG_BAD_DCRC;
        else if (r < 85) kind = IMG_SHORT;
        else kind = IMG_NOISE;
        if (kind == IMG_SHORT) build_image(kind, $urandom_range(63, 1));
        else if (kind == IMG_NOISE) build_image(kind, $urandom_range(120, 1));
        else if ($urandom_range(9) == 0) build_image(kind, $urandom_range(160, 41));
        else build_image(kind, $urandom_range(40));
        send_image();
        phase_bytes += img_q.size();
        phase_imgs++;
      end
    end

    idle_pct  = 0;
    stall_pct = 0;
    settle(8);
    if (failures == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: uimage_header_verifier.f
rtl/core/uhv_pkg.sv
rtl/core/uhv_crc_byte.sv
rtl/core/uimage_header_verifier.sv
rtl/core/uhv_checker.sv
test/uhv_checker.sv
test/tb.sv
